>>> rtl/core/ftsq_pkg.sv
// shared types, widths and codes of the fixed step time quantizer
package ftsq_pkg;

  // field widths
  localparam int ELAPSED_W  = 32;
  localparam int MAXDT_W    = 32;
  localparam int PERIOD_W   = 24;
  localparam int SPEED_W    = 16;
  localparam int OFFSET_W   = 41;
  localparam int CLOCK_W    = 62;
  localparam int SUM_W      = 33;
  localparam int SIMDT_W    = 49;
  localparam int PROT_W     = 63;

  // speed factor fraction bits
  localparam int SPEED_FRAC_BITS = 8;

  // datapath sizes
  localparam int ADD_W      = 63;
  localparam int PROD_W     = SUM_W + SPEED_W;
  localparam int DIV_STEPS  = SUM_W;
  localparam int MUL_STEPS  = SPEED_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 62;

  // register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(8333);
  localparam logic [SPEED_W-1:0]  SPEED_RESET  = SPEED_W'(256);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FRAME_DT      = 3'd0,
    REG_MODEL_STEP_PERIOD = 3'd1,
    REG_SPEED_FACTOR      = 3'd2,
    REG_CLOCK_OFFSET      = 3'd3,
    REG_CLOCK_START       = 3'd4
  } cfg_reg_e;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [MAXDT_W-1:0]  max_frame_dt;
    logic [PERIOD_W-1:0] model_step_period;
    logic [SPEED_W-1:0]  speed_factor;
    logic [OFFSET_W-1:0] clock_offset;
    logic [CLOCK_W-1:0]  clock_start;
  } cfg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_ADV1,
    ST_DIV,
    ST_RDT,
    ST_ADV2,
    ST_MUL,
    ST_STEADY,
    ST_SIM,
    ST_PROT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/ftsq_if.sv
// valid/ready channel interfaces for frame words and result words
interface ftsq_in_if;
  logic                            valid;
  logic                            ready;
  logic [ftsq_pkg::ELAPSED_W-1:0]  elapsed_ticks;
  logic                            freeze;
  logic                            scenery_ready;

  modport source (output valid, output elapsed_ticks, output freeze, output scenery_ready,
                  input ready);
  modport sink   (input valid, input elapsed_ticks, input freeze, input scenery_ready,
                  output ready);
endinterface

interface ftsq_out_if;
  logic                              valid;
  logic                              ready;
  logic [ftsq_pkg::SUM_W-1:0]        step_count;
  logic [ftsq_pkg::SUM_W-1:0]        real_dt;
  logic [ftsq_pkg::SIMDT_W-1:0]      sim_dt;
  logic [ftsq_pkg::CLOCK_W-1:0]      steady_time;
  logic signed [ftsq_pkg::PROT_W-1:0] protocol_time;
  logic [ftsq_pkg::CLOCK_W-1:0]      total_sim_time;

  modport source (output valid, output step_count, output real_dt, output sim_dt,
                  output steady_time, output protocol_time, output total_sim_time,
                  input ready);
  modport sink   (input valid, input step_count, input real_dt, input sim_dt,
                  input steady_time, input protocol_time, input total_sim_time,
                  output ready);
endinterface

>>> rtl/core/ftsq_cfg_regs.sv
// configuration register file with write decode and reset values
module ftsq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ftsq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ftsq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ftsq_pkg::cfg_t                 cfg
);
  import ftsq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // write decode, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAX_FRAME_DT:      cfg_nxt.max_frame_dt      = cfg_wdata[MAXDT_W-1:0];
        REG_MODEL_STEP_PERIOD: cfg_nxt.model_step_period = cfg_wdata[PERIOD_W-1:0];
        REG_SPEED_FACTOR:      cfg_nxt.speed_factor      = cfg_wdata[SPEED_W-1:0];
        REG_CLOCK_OFFSET:      cfg_nxt.clock_offset      = cfg_wdata[OFFSET_W-1:0];
        REG_CLOCK_START:       cfg_nxt.clock_start       = cfg_wdata[CLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_dt      <= '0;
      cfg_r.model_step_period <= PERIOD_RESET;
      cfg_r.speed_factor      <= SPEED_RESET;
      cfg_r.clock_offset      <= '0;
      cfg_r.clock_start       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/fixed_step_time_quantizer_core.sv
// Fixed step time quantizer: one frame word in gives one result word out. A frame passes
// from acceptance to the output register under a sequencer, with its sums and the
// division and multiply steps on one shared 63-bit adder: the restoring division of the
// frame time plus carried remainder by the step period (one quotient bit a cycle), the
// shift-add multiply by the speed factor, the sums, remainder and clock updates, and the
// release into the output register, which waits while an untaken result is held. in_ready
// is high only while the sequencer is idle, so a frame is not taken before the previous one
// is released; a finished result waits in the output register, so the next frame can start
// while the previous result is still untaken. There is no clearing pass after reset.
module fixed_step_time_quantizer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  ftsq_in_if.sink                        in_ch,
  ftsq_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ftsq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ftsq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ftsq_pkg::*;

  cfg_t cfg;

  // configuration registers
  ftsq_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  state_t              state_r,   state_nxt;
  logic [CNT_W-1:0]    cnt_r,     cnt_nxt;
  logic                started_r, started_nxt;
  logic [PERIOD_W-1:0] rem_r,     rem_nxt;
  logic [CLOCK_W-1:0]  steady_r,  steady_nxt;
  logic [CLOCK_W-1:0]  simsum_r,  simsum_nxt;
  logic                ovalid_r,  ovalid_nxt;

  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [ELAPSED_W-1:0] dt_r,      dt_nxt;
  logic [PERIOD_W-1:0]  period_r,  period_nxt;
  logic                 zsim_r,    zsim_nxt;
  logic [SUM_W-1:0]     sum_r,     sum_nxt;
  logic [SUM_W-1:0]     dvd_r,     dvd_nxt;
  logic [SUM_W-1:0]     q_r,       q_nxt;
  logic [PERIOD_W-1:0]  p_r,       p_nxt;
  logic [SUM_W-1:0]     rdt_r,     rdt_nxt;
  logic [SUM_W-1:0]     adv_r,     adv_nxt;
  logic [SPEED_W-1:0]   spd_r,     spd_nxt;
  logic [PROD_W-1:0]    acc_r,     acc_nxt;
  logic [SIMDT_W-1:0]   simdt_r,   simdt_nxt;
  logic [PROT_W-1:0]    prot_r,    prot_nxt;

  logic [SUM_W-1:0]     o_steps_r,  o_rdt_r;
  logic [SIMDT_W-1:0]   o_simdt_r;
  logic [CLOCK_W-1:0]   o_steady_r, o_simsum_r;
  logic [PROT_W-1:0]    o_prot_r;

  logic [ADD_W-1:0]     add_a, add_b, add_res;
  logic                 add_cin;
  logic                 in_acc;
  logic                 out_free;
  logic [ELAPSED_W-1:0] elapsed_eff;
  logic [PERIOD_W:0]    trial_div;
  logic                 trial_neg;
  logic [SIMDT_W-1:0]   simdt_w;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !ovalid_r || out_ch.ready;
  assign elapsed_eff = started_r ? in_ch.elapsed_ticks : '0;
  assign trial_div   = {p_r, dvd_r[SUM_W-1]};
  assign trial_neg   = add_res[ADD_W-1];
  assign simdt_w     = zsim_r ? '0 : SIMDT_W'(acc_r >> SPEED_FRAC_BITS);

  // shared adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_r)
      ST_SUM: begin
        add_a = ADD_W'(dt_r);
        add_b = ADD_W'(rem_r);
      end
      ST_ADV1: begin
        add_a = ADD_W'(elapsed_r);
        add_b = ADD_W'(rem_r);
      end
      ST_DIV: begin
        add_a   = ADD_W'(trial_div);
        add_b   = ~ADD_W'(period_r);
        add_cin = 1'b1;
      end
      ST_RDT: begin
        add_a   = ADD_W'(sum_r);
        add_b   = ~ADD_W'(p_r);
        add_cin = 1'b1;
      end
      ST_ADV2: begin
        add_a   = ADD_W'(adv_r);
        add_b   = ~ADD_W'(p_r);
        add_cin = 1'b1;
      end
      ST_MUL: begin
        add_a = ADD_W'({acc_r[PROD_W-2:0], 1'b0});
        add_b = spd_r[SPEED_W-1] ? ADD_W'(rdt_r) : '0;
      end
      ST_STEADY: begin
        add_a = ADD_W'(steady_r);
        add_b = ADD_W'(adv_r);
      end
      ST_SIM: begin
        add_a = ADD_W'(simsum_r);
        add_b = ADD_W'(simdt_w);
      end
      ST_PROT: begin
        add_a = ADD_W'(steady_r);
        add_b = ADD_W'($signed(cfg.clock_offset));
      end
      default: ;
    endcase
  end

  assign add_res = add_a + add_b + ADD_W'(add_cin);

  // sequencer next state and datapath updates
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    rem_nxt     = rem_r;
    steady_nxt  = steady_r;
    simsum_nxt  = simsum_r;
    ovalid_nxt  = ovalid_r;
    elapsed_nxt = elapsed_r;
    dt_nxt      = dt_r;
    period_nxt  = period_r;
    zsim_nxt    = zsim_r;
    sum_nxt     = sum_r;
    dvd_nxt     = dvd_r;
    q_nxt       = q_r;
    p_nxt       = p_r;
    rdt_nxt     = rdt_r;
    adv_nxt     = adv_r;
    spd_nxt     = spd_r;
    acc_nxt     = acc_r;
    simdt_nxt   = simdt_r;
    prot_nxt    = prot_r;

    // output word leaves on its handshake
    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          elapsed_nxt = elapsed_eff;
          if (cfg.max_frame_dt != '0 && cfg.max_frame_dt < elapsed_eff) begin
            dt_nxt = cfg.max_frame_dt;
          end else begin
            dt_nxt = elapsed_eff;
          end
          period_nxt = (cfg.model_step_period == '0) ? PERIOD_W'(1) : cfg.model_step_period;
          zsim_nxt   = in_ch.freeze || !in_ch.scenery_ready;
          spd_nxt    = cfg.speed_factor;
          acc_nxt    = '0;
          p_nxt      = '0;
          q_nxt      = '0;
          if (!started_r) begin
            steady_nxt  = cfg.clock_start;
            started_nxt = 1'b1;
          end
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt   = add_res[SUM_W-1:0];
        dvd_nxt   = add_res[SUM_W-1:0];
        state_nxt = ST_ADV1;
      end
      ST_ADV1: begin
        adv_nxt   = add_res[SUM_W-1:0];
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one restoring division step
        p_nxt   = trial_neg ? trial_div[PERIOD_W-1:0] : add_res[PERIOD_W-1:0];
        q_nxt   = {q_r[SUM_W-2:0], !trial_neg};
        dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_RDT;
        end
      end
      ST_RDT: begin
        rdt_nxt   = add_res[SUM_W-1:0];
        state_nxt = ST_ADV2;
      end
      ST_ADV2: begin
        adv_nxt   = add_res[SUM_W-1:0];
        rem_nxt   = p_r;
        cnt_nxt   = CNT_W'(MUL_STEPS - 1);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // msb-first shift-add multiply by the speed factor
        acc_nxt = add_res[PROD_W-1:0];
        spd_nxt = {spd_r[SPEED_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_STEADY;
        end
      end
      ST_STEADY: begin
        steady_nxt = add_res[CLOCK_W-1:0];
        state_nxt  = ST_SIM;
      end
      ST_SIM: begin
        simdt_nxt  = simdt_w;
        simsum_nxt = add_res[CLOCK_W-1:0];
        state_nxt  = ST_PROT;
      end
      ST_PROT: begin
        prot_nxt  = add_res[PROT_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      started_r <= 1'b0;
      rem_r     <= '0;
      steady_r  <= '0;
      simsum_r  <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
      rem_r     <= rem_nxt;
      steady_r  <= steady_nxt;
      simsum_r  <= simsum_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    dt_r      <= dt_nxt;
    period_r  <= period_nxt;
    zsim_r    <= zsim_nxt;
    sum_r     <= sum_nxt;
    dvd_r     <= dvd_nxt;
    q_r       <= q_nxt;
    p_r       <= p_nxt;
    rdt_r     <= rdt_nxt;
    adv_r     <= adv_nxt;
    spd_r     <= spd_nxt;
    acc_r     <= acc_nxt;
    simdt_r   <= simdt_nxt;
    prot_r    <= prot_nxt;
  end

  // output register, loaded when the result word is released
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      o_steps_r  <= q_r;
      o_rdt_r    <= rdt_r;
      o_simdt_r  <= simdt_r;
      o_steady_r <= steady_r;
      o_prot_r   <= prot_r;
      o_simsum_r <= simsum_r;
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = ovalid_r;
  assign out_ch.step_count     = o_steps_r;
  assign out_ch.real_dt        = o_rdt_r;
  assign out_ch.sim_dt         = o_simdt_r;
  assign out_ch.steady_time    = o_steady_r;
  assign out_ch.protocol_time  = $signed(o_prot_r);
  assign out_ch.total_sim_time = o_simsum_r;

endmodule

>>> rtl/core/ftsq_checker.sv
// port-level checker for the quantizer core and its bind
module ftsq_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ftsq_pkg::SUM_W-1:0]    out_step_count,
  input logic [ftsq_pkg::SUM_W-1:0]    out_real_dt,
  input logic [ftsq_pkg::SIMDT_W-1:0]  out_sim_dt,
  input logic [ftsq_pkg::CLOCK_W-1:0]  out_steady_time,
  input logic [ftsq_pkg::CLOCK_W-1:0]  out_total_sim_time
);
  import ftsq_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its step count, steady time and total sim time
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_step_count) && $stable(out_steady_time)
      && $stable(out_total_sim_time))
    else $error("result payload changed while stalled");

  // one frame at a time: ready drops right after a frame word is taken
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("frame word taken while busy");

  // zero steps means zero quantized real time
  a_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_count == '0 |-> out_real_dt == '0)
    else $error("real dt nonzero with zero steps");

  // no sim time without real time
  a_zero_sim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_real_dt == '0 |-> out_sim_dt == '0)
    else $error("sim dt nonzero with zero real dt");

endmodule

bind fixed_step_time_quantizer_core ftsq_port_checker u_ftsq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_step_count     (out_ch.step_count),
  .out_real_dt        (out_ch.real_dt),
  .out_sim_dt         (out_ch.sim_dt),
  .out_steady_time    (out_ch.steady_time),
  .out_total_sim_time (out_ch.total_sim_time)
);
